[rtl/core/cmgs_pkg.sv]
`timescale 1ns / 1ps
package cmgs_pkg;

    typedef enum logic [2:0] {
        ACT_RX     = 3'd0,
        ACT_HOST   = 3'd1,
        ACT_RUN    = 3'd2,
        ACT_LOST   = 3'd3,
        ACT_TICK   = 3'd4,
        ACT_REPORT = 3'd5
    } t_action;

    typedef enum logic [2:0] {
        CFG_NUMBERS  = 3'd0,
        CFG_MODES    = 3'd1,
        CFG_PERIOD   = 3'd2,
        CFG_CMD_ID   = 3'd3,
        CFG_RESET_LS = 3'd4
    } t_cfg_index;

    typedef enum logic [1:0] {
        LINK_OFFLINE  = 2'd0,
        LINK_FEEDBACK = 2'd1,
        LINK_ONLINE   = 2'd2,
        LINK_SPARE    = 2'd3
    } t_link;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_EMIT_MODE,
        ST_EMIT_FB,
        ST_EMIT_CMD,
        ST_REPORT,
        ST_WAIT
    } t_state;

    localparam logic [10:0] REPORT_BASE       = 11'h096;
    localparam logic [7:0]  MODE_DISABLED     = 8'h09;
    localparam logic [10:0] MODE_FRAME_ID     = 11'h105;
    localparam logic [10:0] FEEDBACK_FRAME_ID = 11'h106;
    localparam logic [6:0]  RATE_MASK         = 7'h7F;

    typedef struct packed {
        logic [2:0]         action;
        logic [10:0]        frame_id;
        logic [63:0]        frame_data;
        logic [1:0]         motor_slot;
        logic               enable_request;
        logic signed [15:0] command_value;
    } t_in_item;

    typedef struct packed {
        logic               kind;
        logic [10:0]        tx_id;
        logic [63:0]        tx_data;
        logic               last;
        logic               online;
        logic [15:0]        position;
        logic signed [15:0] speed;
        logic signed [15:0] current;
        logic [7:0]         report_mode;
        logic [7:0]         error_code;
    } t_out_item;

endpackage

[rtl/core/can_motor_group_supervisor.sv]
`timescale 1ns / 1ps
// Channel | Direction | Handshake            | Payload
// in      | input     | i_in_valid/o_in_ready | cmgs_pkg::t_in_item
// out     | output    | o_out_valid/i_out_ready | cmgs_pkg::t_out_item
// cfg     | input     | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
// A run is accepted, walks all NUM_SLOTS slots and then passes through the emit and
// wait states; each result that it emits is held until taken.
// A received frame walks the slots until a match or the last slot; a report passes
// through the report and wait states, and every other item goes straight back to idle.
// Each result waits in the output register until taken; the block accepts no item meanwhile.
// Reset (synchronous, active low) clears link states, counters and reports.
module can_motor_group_supervisor #(
    parameter int NUM_SLOTS     = 4,
    parameter int TIMEOUT_TICKS = 100
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  cmgs_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output cmgs_pkg::t_out_item  o_out_item,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [2:0]           i_cfg_index,
    input  logic [31:0]          i_cfg_data
);
    import cmgs_pkg::*;

    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [15:0] TMO = 16'(TIMEOUT_TICKS);

    // Configuration registers.
    logic [15:0] r_numbers;
    logic [31:0] r_modes;
    logic [15:0] r_period;
    logic [10:0] r_cmd_id;
    logic        r_reset_ls;

    // Per-slot state.
    t_link       r_link   [NUM_SLOTS];
    logic [15:0] r_silent [NUM_SLOTS];
    logic        r_heard  [NUM_SLOTS];
    logic [63:0] r_rep    [NUM_SLOTS];
    logic        r_en     [NUM_SLOTS];
    logic [15:0] r_cmd    [NUM_SLOTS];

    // Sequencer state.
    t_state      r_state, n_state;
    t_in_item    r_item;
    logic [SW-1:0] r_slot;
    logic        r_done;
    logic [63:0] r_modebuf, r_fbbuf, r_cmdbuf;
    logic [2:0]  r_present, r_mc, r_fc;
    t_out_item   r_out;
    logic        r_out_valid;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == ST_IDLE) && !r_out_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Current slot signals for the shared walk unit.
    logic [3:0]  cur_num;
    logic        cur_present, cur_online, cur_last;
    logic [2:0]  cur_idx;
    logic        cur_inbuf;
    logic [7:0]  cur_mode_cfg, cur_rmode;
    t_link       cur_link;
    always_comb begin
        cur_num      = r_numbers[{r_slot, 2'b00} +: 4];
        cur_present  = cur_num != 4'd0;
        cur_online   = r_heard[r_slot] && (r_silent[r_slot] < TMO);
        cur_last     = 32'(r_slot) == NUM_SLOTS - 1;
        cur_idx      = 3'(cur_num - 4'd1);
        cur_inbuf    = !cur_num[3] || (cur_num == 4'd8);
        cur_mode_cfg = r_modes[{r_slot, 3'b000} +: 8];
        cur_rmode    = r_rep[r_slot][7:0];
        cur_link     = cur_online ? r_link[r_slot] : LINK_OFFLINE;
    end

    logic want_cmd;
    assign want_cmd = !(r_mc == r_present || r_fc == r_present);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    case (i_in_item.action)
                        ACT_RX, ACT_RUN: n_state = ST_WALK;
                        ACT_REPORT:      n_state = ST_REPORT;
                        default:         n_state = ST_IDLE;
                    endcase
                end
            end
            ST_WALK: begin
                if (cur_last || (r_item.action == ACT_RX && r_done)) begin
                    n_state = (r_item.action == ACT_RUN) ? ST_EMIT_MODE : ST_IDLE;
                end
            end
            ST_EMIT_MODE: if (!r_out_valid) n_state = ST_EMIT_FB;
            ST_EMIT_FB:   if (!r_out_valid) n_state = ST_EMIT_CMD;
            ST_EMIT_CMD:  if (!r_out_valid) n_state = ST_WAIT;
            ST_REPORT:    if (!r_out_valid) n_state = ST_WAIT;
            ST_WAIT:      if (!r_out_valid) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_numbers <= '0; r_modes <= '0; r_period <= '0;
            r_cmd_id <= '0; r_reset_ls <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_NUMBERS:  r_numbers  <= i_cfg_data[15:0];
                CFG_MODES:    r_modes    <= i_cfg_data;
                CFG_PERIOD:   r_period   <= i_cfg_data[15:0];
                CFG_CMD_ID:   r_cmd_id   <= i_cfg_data[10:0];
                CFG_RESET_LS: r_reset_ls <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Datapath: item capture, slot walk, result emission.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_SLOTS; s++) begin
                r_link[s] <= LINK_OFFLINE; r_silent[s] <= TMO; r_heard[s] <= 1'b0;
                r_rep[s] <= '0; r_en[s] <= 1'b0; r_cmd[s] <= '0;
            end
            r_out_valid <= 1'b0;
            r_slot <= '0;
            r_done <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid && o_in_ready) begin
                        r_item <= i_in_item;
                        r_slot <= '0;
                        r_done <= 1'b0;
                        r_modebuf <= '0; r_fbbuf <= '0; r_cmdbuf <= '0;
                        r_present <= '0; r_mc <= '0; r_fc <= '0;
                        case (i_in_item.action)
                            ACT_HOST: begin
                                if (32'(i_in_item.motor_slot) < NUM_SLOTS) begin
                                    r_en[SW'(i_in_item.motor_slot)]  <= i_in_item.enable_request;
                                    r_cmd[SW'(i_in_item.motor_slot)] <= i_in_item.command_value;
                                end
                            end
                            ACT_LOST: begin
                                if (r_reset_ls)
                                    for (int s = 0; s < NUM_SLOTS; s++) begin
                                        r_en[s] <= 1'b0; r_cmd[s] <= '0;
                                    end
                            end
                            ACT_TICK: begin
                                for (int s = 0; s < NUM_SLOTS; s++)
                                    if (r_silent[s] < TMO) r_silent[s] <= r_silent[s] + 16'd1;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_WALK: begin
                    r_slot <= r_slot + SW'(1);
                    if (cur_present && r_item.action == ACT_RX && !r_done) begin
                        if (r_link[r_slot] == LINK_FEEDBACK) begin
                            r_link[r_slot] <= LINK_ONLINE;
                        end else if (r_item.frame_id == REPORT_BASE + 11'(cur_num)) begin
                            r_rep[r_slot]    <= r_item.frame_data;
                            r_silent[r_slot] <= '0;
                            r_heard[r_slot]  <= 1'b1;
                            if (r_link[r_slot] == LINK_OFFLINE)
                                r_link[r_slot] <= LINK_FEEDBACK;
                            r_done <= 1'b1;
                        end
                    end
                    if (cur_present && r_item.action == ACT_RUN) begin
                        r_present <= r_present + 3'd1;
                        r_link[r_slot] <= cur_link;
                        if (cur_inbuf) begin
                            r_modebuf[(7 - cur_idx) * 8 +: 8] <= cur_mode_cfg;
                            r_fbbuf[(7 - cur_idx) * 8 +: 8]   <= {1'b0, r_period[6:0] & RATE_MASK};
                        end
                        case (cur_link)
                            LINK_OFFLINE: begin
                                r_mc <= r_mc + 3'd1;
                                if (cur_inbuf) r_modebuf[(7 - cur_idx) * 8 +: 8] <= MODE_DISABLED;
                            end
                            LINK_FEEDBACK: r_fc <= r_fc + 3'd1;
                            LINK_ONLINE: begin
                                if (r_en[r_slot]) begin
                                    if (cur_rmode == MODE_DISABLED) r_mc <= r_mc + 3'd1;
                                    else r_cmdbuf[(3 - cur_idx[1:0]) * 16 +: 16] <= r_cmd[r_slot];
                                end else if (cur_rmode != MODE_DISABLED) begin
                                    r_mc <= r_mc + 3'd1;
                                    if (cur_inbuf)
                                        r_modebuf[(7 - cur_idx) * 8 +: 8] <= MODE_DISABLED;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_EMIT_MODE: begin
                    if (!r_out_valid && r_mc != 3'd0) begin
                        r_out <= '0;
                        r_out.tx_id <= MODE_FRAME_ID;
                        r_out.tx_data <= r_modebuf;
                        r_out.last <= (r_fc == 3'd0) && !want_cmd;
                        r_out_valid <= 1'b1;
                    end
                end
                ST_EMIT_FB: begin
                    if (!r_out_valid && r_fc != 3'd0) begin
                        r_out <= '0;
                        r_out.tx_id <= FEEDBACK_FRAME_ID;
                        r_out.tx_data <= r_fbbuf;
                        r_out.last <= !want_cmd;
                        r_out_valid <= 1'b1;
                    end
                end
                ST_EMIT_CMD: begin
                    if (!r_out_valid && want_cmd) begin
                        r_out <= '0;
                        r_out.tx_id <= r_cmd_id;
                        r_out.tx_data <= r_cmdbuf;
                        r_out.last <= 1'b1;
                        r_out_valid <= 1'b1;
                    end
                end
                ST_REPORT: begin
                    if (!r_out_valid) begin
                        r_out <= '0;
                        r_out.kind <= 1'b1;
                        r_out.last <= 1'b1;
                        if (32'(r_item.motor_slot) < NUM_SLOTS) begin
                            r_out.online <= r_heard[SW'(r_item.motor_slot)]
                                && (r_silent[SW'(r_item.motor_slot)] < TMO);
                            r_out.speed    <= r_rep[SW'(r_item.motor_slot)][63:48];
                            r_out.current  <= r_rep[SW'(r_item.motor_slot)][47:32];
                            r_out.position <= r_rep[SW'(r_item.motor_slot)][31:16];
                            r_out.error_code  <= r_rep[SW'(r_item.motor_slot)][15:8];
                            r_out.report_mode <= r_rep[SW'(r_item.motor_slot)][7:0];
                        end
                        r_out_valid <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

[sim/tb_can_motor_group_supervisor.sv]
`timescale 1ns / 1ps
module tb_can_motor_group_supervisor;
    import cmgs_pkg::*;

    localparam int SLOTS = 4;
    localparam int TIMEOUT = 100;
    localparam int WATCHDOG_LIMIT = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_item    i_in_item;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_item   o_out_item;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    can_motor_group_supervisor #(.NUM_SLOTS(SLOTS), .TIMEOUT_TICKS(TIMEOUT)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_item(i_in_item),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_item(o_out_item),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // Predicted supervisor state and registers.
    logic [15:0] reg_numbers;
    logic [31:0] reg_modes;
    logic [15:0] reg_period;
    logic [10:0] reg_cmd_id;
    logic        reg_reset_ls;
    t_link       m_link [SLOTS];
    logic [15:0] m_silence [SLOTS];
    logic        m_heard [SLOTS];
    logic [15:0] m_speed [SLOTS];
    logic [15:0] m_current [SLOTS];
    logic [15:0] m_position [SLOTS];
    logic [15:0] m_status [SLOTS];
    logic        m_enable [SLOTS];
    logic [15:0] m_command [SLOTS];

    t_in_item  pending_items[$];
    t_out_item expected_results[$];
    int        fail_count = 0;
    int        watchdog = 0;
    bit        stim_done = 0;
    int        in_wait = 0;
    int        out_wait = 0;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [3:0] number_of(int s);
        return reg_numbers[4*s +: 4];
    endfunction

    function automatic bit present(int s);
        return number_of(s) != 0;
    endfunction

    function automatic bit slot_up(int s);
        return m_heard[s] && m_silence[s] < TIMEOUT;
    endfunction

    function automatic t_out_item frame_result(logic [10:0] id, logic [63:0] data);
        t_out_item r;
        r = '0;
        r.tx_id = id;
        r.tx_data = data;
        return r;
    endfunction

    // Apply one accepted item to the predicted state and queue its results.
    task automatic predict_item(t_in_item it);
        t_out_item res[$];
        t_out_item r;
        logic [7:0]  modebuf [8];
        logic [7:0]  fbbuf [8];
        logic [15:0] cmds [4];
        logic [63:0] pk;
        int cnt_present, cnt_mode, cnt_fb, idx;
        logic [7:0] rmode;
        bit inbuf;
        case (it.action)
            ACT_RX: begin
                for (int s = 0; s < SLOTS; s++) begin
                    if (!present(s)) continue;
                    if (m_link[s] == LINK_FEEDBACK) begin
                        m_link[s] = LINK_ONLINE;
                        continue;
                    end
                    if (it.frame_id != REPORT_BASE + number_of(s)) continue;
                    m_speed[s] = it.frame_data[63:48];
                    m_current[s] = it.frame_data[47:32];
                    m_position[s] = it.frame_data[31:16];
                    m_status[s] = it.frame_data[15:0];
                    m_silence[s] = 0;
                    m_heard[s] = 1;
                    if (m_link[s] == LINK_OFFLINE) m_link[s] = LINK_FEEDBACK;
                    break;
                end
            end
            ACT_HOST: begin
                m_enable[it.motor_slot] = it.enable_request;
                m_command[it.motor_slot] = it.command_value;
            end
            ACT_RUN: begin
                cnt_present = 0; cnt_mode = 0; cnt_fb = 0;
                for (int i = 0; i < 8; i++) begin
                    modebuf[i] = 0;
                    fbbuf[i] = 0;
                end
                for (int i = 0; i < 4; i++) cmds[i] = 0;
                for (int s = 0; s < SLOTS; s++) begin
                    if (!present(s)) continue;
                    cnt_present++;
                    idx = number_of(s) - 1;
                    inbuf = idx < 8;
                    if (!slot_up(s)) m_link[s] = LINK_OFFLINE;
                    if (inbuf) begin
                        modebuf[idx] = reg_modes[8*s +: 8];
                        fbbuf[idx] = {1'b0, reg_period[6:0] & RATE_MASK};
                    end
                    rmode = m_status[s][7:0];
                    case (m_link[s])
                        LINK_OFFLINE: begin
                            cnt_mode++;
                            if (inbuf) modebuf[idx] = MODE_DISABLED;
                        end
                        LINK_FEEDBACK: cnt_fb++;
                        LINK_ONLINE: begin
                            if (m_enable[s]) begin
                                if (rmode == MODE_DISABLED) cnt_mode++;
                                else cmds[idx % 4] = m_command[s];
                            end else if (rmode != MODE_DISABLED) begin
                                cnt_mode++;
                                if (inbuf) modebuf[idx] = MODE_DISABLED;
                            end
                        end
                        default: ;
                    endcase
                end
                if (cnt_mode != 0) begin
                    for (int i = 0; i < 8; i++) pk[63-8*i -: 8] = modebuf[i];
                    res.push_back(frame_result(MODE_FRAME_ID, pk));
                end
                if (cnt_fb != 0) begin
                    for (int i = 0; i < 8; i++) pk[63-8*i -: 8] = fbbuf[i];
                    res.push_back(frame_result(FEEDBACK_FRAME_ID, pk));
                end
                if (!(cnt_mode == cnt_present || cnt_fb == cnt_present))
                    res.push_back(frame_result(reg_cmd_id,
                        {cmds[0], cmds[1], cmds[2], cmds[3]}));
                if (res.size() > 0) res[res.size()-1].last = 1;
                foreach (res[i]) expected_results.push_back(res[i]);
            end
            ACT_LOST: begin
                if (reg_reset_ls)
                    for (int s = 0; s < SLOTS; s++) begin
                        m_enable[s] = 0;
                        m_command[s] = 0;
                    end
            end
            ACT_TICK: begin
                for (int s = 0; s < SLOTS; s++)
                    if (m_silence[s] < TIMEOUT) m_silence[s]++;
            end
            ACT_REPORT: begin
                r = '0;
                r.kind = 1;
                r.last = 1;
                r.online = slot_up(it.motor_slot);
                r.position = m_position[it.motor_slot];
                r.speed = m_speed[it.motor_slot];
                r.current = m_current[it.motor_slot];
                r.report_mode = m_status[it.motor_slot][7:0];
                r.error_code = m_status[it.motor_slot][15:8];
                expected_results.push_back(r);
            end
            default: ;
        endcase
    endtask

    // Input driver: takes items from the pending queue with random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 0;
            i_in_item <= '0;
            in_wait <= $urandom_range(0, 18);
        end else begin
            if (i_in_valid && o_in_ready) begin
                predict_item(i_in_item);
                in_wait <= $urandom_range(0, 18);
                i_in_valid <= 0;
            end else if (!i_in_valid) begin
                if (in_wait > 0) begin
                    in_wait <= in_wait - 1;
                end else if (pending_items.size() > 0) begin
                    i_in_item <= pending_items.pop_front();
                    i_in_valid <= 1;
                end
            end
        end
    end

    // Output monitor: random stalls, field-by-field comparison.
    always @(posedge i_clk) begin
        t_out_item e;
        if (!i_rst_n) begin
            i_out_ready <= 0;
            out_wait <= 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result kind=%0d", o_out_item.kind);
                    fail_count++;
                end else begin
                    e = expected_results.pop_front();
                    if (e.kind !== o_out_item.kind) begin
                        $error("kind exp %0h got %0h", e.kind, o_out_item.kind); fail_count++;
                    end
                    if (e.tx_id !== o_out_item.tx_id) begin
                        $error("tx_id exp %0h got %0h", e.tx_id, o_out_item.tx_id); fail_count++;
                    end
                    if (e.tx_data !== o_out_item.tx_data) begin
                        $error("tx_data exp %0h got %0h", e.tx_data, o_out_item.tx_data);
                        fail_count++;
                    end
                    if (e.last !== o_out_item.last) begin
                        $error("last exp %0h got %0h", e.last, o_out_item.last); fail_count++;
                    end
                    if (e.online !== o_out_item.online) begin
                        $error("online exp %0h got %0h", e.online, o_out_item.online);
                        fail_count++;
                    end
                    if (e.position !== o_out_item.position) begin
                        $error("position exp %0h got %0h", e.position, o_out_item.position);
                        fail_count++;
                    end
                    if (e.speed !== o_out_item.speed) begin
                        $error("speed exp %0h got %0h", e.speed, o_out_item.speed); fail_count++;
                    end
                    if (e.current !== o_out_item.current) begin
                        $error("current exp %0h got %0h", e.current, o_out_item.current);
                        fail_count++;
                    end
                    if (e.report_mode !== o_out_item.report_mode) begin
                        $error("report_mode exp %0h got %0h", e.report_mode,
                               o_out_item.report_mode);
                        fail_count++;
                    end
                    if (e.error_code !== o_out_item.error_code) begin
                        $error("error_code exp %0h got %0h", e.error_code,
                               o_out_item.error_code);
                        fail_count++;
                    end
                end
                i_out_ready <= 0;
                out_wait <= $urandom_range(0, 18);
            end else if (!i_out_ready) begin
                if (out_wait > 0) out_wait <= out_wait - 1;
                else i_out_ready <= 1;
            end
        end
    end

    // Watchdog on cycles with no accepted item on any channel.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n || stim_done)
            watchdog <= 0;
        else
            watchdog <= watchdog + 1;
        if (watchdog >= WATCHDOG_LIMIT) begin
            $display("tb_can_motor_group_supervisor NOT OK");
            $finish;
        end
    end

    task automatic write_reg(t_cfg_index idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_index <= idx;
        i_cfg_data <= val;
        i_cfg_valid <= 1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 0;
        case (idx)
            CFG_NUMBERS:  reg_numbers = val[15:0];
            CFG_MODES:    reg_modes = val;
            CFG_PERIOD:   reg_period = val[15:0];
            CFG_CMD_ID:   reg_cmd_id = val[10:0];
            CFG_RESET_LS: reg_reset_ls = val[0];
            default: ;
        endcase
    endtask

    // Wait until the block has drained all queued work. The check is made at the
    // falling edge so that the driver's and monitor's updates have settled.
    task automatic drain();
        @(negedge i_clk);
        while (pending_items.size() > 0 || i_in_valid || expected_results.size() > 0)
            @(negedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic t_in_item make_item(t_action a, logic [10:0] id,
                                           logic [63:0] d, logic [1:0] slot,
                                           logic en, logic [15:0] cmd);
        t_in_item it;
        it.action = a;
        it.frame_id = id;
        it.frame_data = d;
        it.motor_slot = slot;
        it.enable_request = en;
        it.command_value = cmd;
        return it;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // A random item, biased towards report frames of configured motors.
    function automatic t_in_item random_item();
        t_in_item it;
        int pick;
        int s;
        it = make_item(t_action'(3'($urandom_range(0, 7))), 11'($urandom),
                       rand64(), 2'($urandom), 1'($urandom), 16'($urandom));
        pick = $urandom_range(0, 99);
        s = $urandom_range(0, 3);
        if (pick < 30) begin
            it.action = ACT_RX;
            it.frame_id = REPORT_BASE + reg_numbers[4*s +: 4];
            if ($urandom_range(0, 2) == 0) it.frame_data[7:0] = MODE_DISABLED;
        end else if (pick < 48) it.action = ACT_RUN;
        else if (pick < 60) it.action = ACT_HOST;
        else if (pick < 72) it.action = ACT_REPORT;
        else if (pick < 84) it.action = ACT_TICK;
        else if (pick < 88) it.action = ACT_LOST;
        return it;
    endfunction

    initial begin
        i_rst_n = 0;
        i_cfg_valid = 0;
        i_cfg_index = CFG_NUMBERS;
        i_cfg_data = '0;
        reg_numbers = 0; reg_modes = 0; reg_period = 0; reg_cmd_id = 0; reg_reset_ls = 0;
        for (int s = 0; s < SLOTS; s++) begin
            m_link[s] = LINK_OFFLINE; m_silence[s] = TIMEOUT; m_heard[s] = 0;
            m_speed[s] = 0; m_current[s] = 0; m_position[s] = 0; m_status[s] = 0;
            m_enable[s] = 0; m_command[s] = 0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;

        // Directed part: bring motors online, run, extremes and special cases.
        write_reg(CFG_NUMBERS, 32'h0000_9421);
        write_reg(CFG_MODES, 32'hFF00_0A55);
        write_reg(CFG_PERIOD, 32'h0000_FFFF);
        write_reg(CFG_CMD_ID, 32'h0000_07FF);
        write_reg(CFG_RESET_LS, 32'h1);
        pending_items.push_back(make_item(ACT_RUN, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(ACT_REPORT, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(ACT_RX, 11'h097, 64'hFFFF_FFFF_FFFF_FF05, 0, 0, 0));
        pending_items.push_back(make_item(ACT_RX, 11'h09A, 64'h8000_7FFF_0000_0009, 0, 0, 0));
        pending_items.push_back(make_item(ACT_RUN, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(ACT_RX, 11'h09F, 64'h0123_4567_89AB_CDEF, 0, 0, 0));
        pending_items.push_back(make_item(ACT_RX, 11'h7FF, 64'h0, 0, 0, 0));
        pending_items.push_back(make_item(ACT_HOST, 0, 0, 0, 1, 16'h8000));
        pending_items.push_back(make_item(ACT_HOST, 0, 0, 1, 1, 16'h7FFF));
        pending_items.push_back(make_item(ACT_HOST, 0, 0, 3, 1, 16'hFFFF));
        pending_items.push_back(make_item(ACT_RUN, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(ACT_REPORT, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(ACT_REPORT, 0, 0, 1, 0, 0));
        pending_items.push_back(make_item(ACT_REPORT, 0, 0, 3, 0, 0));
        pending_items.push_back(make_item(ACT_LOST, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(ACT_RUN, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(t_action'(3'd6), 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(t_action'(3'd7), 0, 0, 0, 0, 0));
        for (int i = 0; i < 4; i++)
            pending_items.push_back(make_item(ACT_TICK, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(ACT_RUN, 0, 0, 0, 0, 0));
        drain();

        // Random phases across several register settings; one phase holds a
        // burst of ticks long enough to time every motor out.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: write_reg(CFG_NUMBERS, 32'h0);
                1: write_reg(CFG_NUMBERS, 32'hFFFF);
                2: write_reg(CFG_NUMBERS, 32'h8765);
                default: write_reg(CFG_NUMBERS, 32'($urandom));
            endcase
            write_reg(CFG_MODES, ph == 1 ? 32'hFFFF_FFFF : (ph == 0 ? 32'h0 : $urandom));
            write_reg(CFG_PERIOD, ph == 1 ? 32'hFFFF : (ph == 0 ? 32'h0 : $urandom));
            write_reg(CFG_CMD_ID, ph == 0 ? 32'h0 : 32'($urandom));
            write_reg(CFG_RESET_LS, ph % 2);
            for (int i = 0; i < 58; i++) begin
                if (i == 29)
                    for (int t = 0; t < (ph == 3 ? 100 : 0); t++)
                        pending_items.push_back(make_item(ACT_TICK, 0, 0, 0, 0, 0));
                pending_items.push_back(random_item());
            end
            drain();
        end
        stim_done = 1;
        if (fail_count == 0 && expected_results.size() == 0)
            $display("tb_can_motor_group_supervisor OK");
        else
            $display("tb_can_motor_group_supervisor NOT OK");
        $finish;
    end
endmodule
